FILE: design/bdq_pkg.sv
// shared types and constants for the balanced dual queue
package bdq_pkg;

  // payload widths fixed by the interface
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  // operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_NONE       = 2'd0,
    MODE_ENQ        = 2'd1,
    MODE_POP_FIRST  = 2'd2,
    MODE_POP_SECOND = 2'd3
  } mode_t;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // operation broadcast to every entry cell
  typedef struct packed {
    logic enq_first;
    logic enq_second;
    logic pop_first;
    logic pop_second;
  } cell_op_t;

endpackage

FILE: design/bdq_if.sv
// valid/ready channel interfaces for operations and results

interface bdq_in_if;
  import bdq_pkg::*;

  logic   valid;
  logic   ready;
  mode_t  mode;
  value_t item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface bdq_out_if;
  import bdq_pkg::*;

  logic   valid;
  logic   ready;
  logic   accepted;
  logic   went_to_second;
  logic   first_head_valid;
  value_t first_head_value;
  logic   second_head_valid;
  value_t second_head_value;
  count_t first_count;
  count_t second_count;

  modport source (
    output valid, output accepted, output went_to_second,
    output first_head_valid, output first_head_value,
    output second_head_valid, output second_head_value,
    output first_count, output second_count,
    input ready
  );
  modport sink (
    input valid, input accepted, input went_to_second,
    input first_head_valid, input first_head_value,
    input second_head_valid, input second_head_value,
    input first_count, input second_count,
    output ready
  );
endinterface

FILE: design/bdq_cell.sv
// one entry cell of the shared store, shifts toward either end of the store
module bdq_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  bdq_pkg::cell_op_t op,
  input  logic [CW-1:0]     count_first,
  input  logic [CW-1:0]     second_base,
  input  bdq_pkg::value_t   item_value,
  input  bdq_pkg::value_t   from_up,
  input  bdq_pkg::value_t   from_down,
  output bdq_pkg::value_t   q,
  output bdq_pkg::value_t   q_next
);
  import bdq_pkg::*;

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

  // select the new content of this entry
  always_comb begin
    q_next = q;
    if (op.enq_first && (IDX_C == count_first)) begin
      q_next = item_value;
    end else if (op.enq_second && (IDX_P1 == second_base)) begin
      q_next = item_value;
    end else if (op.pop_first && (IDX_C < count_first)) begin
      q_next = from_up;
    end else if (op.pop_second && (IDX_C >= second_base)) begin
      q_next = from_down;
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: design/balanced_dual_queue_shared_store.sv
// top level: two fifo sub-queues sharing one row of entry cells
//
// The store is a row of DEPTH entry cells. The first sub-queue fills the row
// from cell 0 upward with its oldest entry in cell 0; the second fills it from
// cell DEPTH-1 downward with its oldest entry in cell DEPTH-1. An enqueue goes
// to the shorter sub-queue (the first on a tie) and is refused when the two
// together hold DEPTH entries; a dequeue shifts every entry of its sub-queue
// one cell toward that sub-queue's end, all cells at once. The cell row
// applies each operation as it is accepted, so one transaction is accepted
// per clock; its result appears in the output register on the next cycle. in
// ready is high whenever the output register is empty or being taken, so a new
// operation is accepted in the same cycle that a finished result leaves; while
// a result waits unread, the input stalls. Entries need no clearing after
// reset: only occupied cells are ever reported.
module balanced_dual_queue_shared_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);
  import bdq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_C  = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

  logic [CW-1:0] count_first;
  logic [CW-1:0] count_second;
  logic [CW-1:0] count_first_next;
  logic [CW-1:0] count_second_next;
  logic [CW-1:0] second_base;
  logic [CW:0]   total;
  logic          fire;
  logic          full;
  logic          to_second;
  cell_op_t      op;

  value_t cell_q    [DEPTH];
  value_t cell_next [DEPTH];

  // handshake
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  // decode the operation against the current fill levels
  assign total       = {1'b0, count_first} + {1'b0, count_second};
  assign full        = (total == DEPTH_C);
  assign to_second   = (count_second < count_first);
  assign second_base = DEPTH_CW - count_second;

  always_comb begin
    op = '0;
    if (fire) begin
      case (in_ch.mode)
        MODE_ENQ: begin
          op.enq_first  = !full && !to_second;
          op.enq_second = !full && to_second;
        end
        MODE_POP_FIRST:  op.pop_first  = (count_first != '0);
        MODE_POP_SECOND: op.pop_second = (count_second != '0);
        default: op = '0;
      endcase
    end
  end

  // fill levels after the operation
  always_comb begin
    count_first_next  = count_first;
    count_second_next = count_second;
    if (op.enq_first) begin
      count_first_next = count_first + 1'b1;
    end
    if (op.enq_second) begin
      count_second_next = count_second + 1'b1;
    end
    if (op.pop_first) begin
      count_first_next = count_first - 1'b1;
    end
    if (op.pop_second) begin
      count_second_next = count_second - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_first  <= '0;
      count_second <= '0;
    end else begin
      count_first  <= count_first_next;
      count_second <= count_second_next;
    end
  end

  // row of entry cells, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t up_d;
    value_t down_d;

    if (i == DEPTH - 1) begin : g_top
      assign up_d = '0;
    end else begin : g_mid_up
      assign up_d = cell_q[i+1];
    end
    if (i == 0) begin : g_bot
      assign down_d = '0;
    end else begin : g_mid_down
      assign down_d = cell_q[i-1];
    end

    bdq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i),
      .CW    (CW)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .count_first (count_first),
      .second_base (second_base),
      .item_value  (in_ch.item_value),
      .from_up     (up_d),
      .from_down   (down_d),
      .q           (cell_q[i]),
      .q_next      (cell_next[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.accepted          <= |op;
      out_ch.went_to_second    <= op.enq_second;
      out_ch.first_head_valid  <= (count_first_next != '0);
      out_ch.first_head_value  <= (count_first_next != '0) ? cell_next[0] : '0;
      out_ch.second_head_valid <= (count_second_next != '0);
      out_ch.second_head_value <= (count_second_next != '0) ? cell_next[DEPTH-1] : '0;
      out_ch.first_count       <= COUNT_W'(count_first_next);
      out_ch.second_count      <= COUNT_W'(count_second_next);
    end
  end

endmodule

FILE: design/bdq_checker.sv
// port-level checks for the balanced dual queue, bound to the top level
module bdq_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            accepted,
  input logic            went_to_second,
  input logic            first_head_valid,
  input bdq_pkg::value_t first_head_value,
  input logic            second_head_valid,
  input bdq_pkg::value_t second_head_value,
  input bdq_pkg::count_t first_count,
  input bdq_pkg::count_t second_count
);
  import bdq_pkg::*;

  // an empty output register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(first_head_value) && $stable(second_head_value)
      && $stable(first_count) && $stable(second_count) && $stable(accepted))
    else $error("result changed while stalled");

  // an empty sub-queue reports zero head and zero count
  a_empty_heads: assert property (@(posedge clk) disable iff (rst)
    out_valid && !first_head_valid |-> first_head_value == '0 && first_count == '0)
    else $error("first sub-queue empty but head or count nonzero");

  a_empty_heads2: assert property (@(posedge clk) disable iff (rst)
    out_valid && !second_head_valid |-> second_head_value == '0 && second_count == '0)
    else $error("second sub-queue empty but head or count nonzero");

  // a placement in the second sub-queue leaves it non-empty
  a_placement: assert property (@(posedge clk) disable iff (rst)
    out_valid && went_to_second |-> accepted && second_head_valid)
    else $error("inconsistent placement report");

endmodule

bind balanced_dual_queue_shared_store bdq_checker u_bdq_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .accepted          (out_ch.accepted),
  .went_to_second    (out_ch.went_to_second),
  .first_head_valid  (out_ch.first_head_valid),
  .first_head_value  (out_ch.first_head_value),
  .second_head_valid (out_ch.second_head_valid),
  .second_head_value (out_ch.second_head_value),
  .first_count       (out_ch.first_count),
  .second_count      (out_ch.second_count)
);
